// ===== rtl/dsp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dsp_pkg
// shared constants and types of the shortest path matrix unit
// ----------------------------------------------------------------------------
package dsp_pkg;
	localparam int MAX_NODES_DEF   = 16;
	localparam int WEIGHT_BITS_DEF = 16;
	localparam int DIST_BITS       = 20;
	localparam int NODE_FLD_BITS   = 4;

	localparam logic [1:0] MODE_DIRECTED   = 2'd0;
	localparam logic [1:0] MODE_UNDIRECTED = 2'd1;
	localparam logic [1:0] MODE_CLEAR      = 2'd2;
	localparam logic [1:0] MODE_RUN        = 2'd3;

	localparam logic [1:0] REG_NODE_COUNT = 2'd0;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_WRITE2,
		ST_INIT,
		ST_SCAN,
		ST_RELAX_RD,
		ST_RELAX,
		ST_EMIT_RD,
		ST_EMIT,
		ST_ACK
	} state_t;
endpackage
`default_nettype wire

// ===== rtl/dsp_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dsp_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module dsp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

// ===== rtl/dijkstra_shortest_paths_matrix_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dijkstra_shortest_paths_matrix_unit
// adjacency matrix store with a sequenced shortest path search
// ----------------------------------------------------------------------------
// One request is taken at a time. An edge write, directed or undirected, is
// busy in the WRITE2 and ACK states before its result. A clear writes one
// matrix word a cycle through the single ram port, all MAX_NODES*MAX_NODES
// words for a power-of-two MAX_NODES, and its result follows from ACK; a
// clearing pass over the whole matrix also runs after reset, during which no
// request is taken and no result is given. A run with n nodes in use has up to
// n rounds (one per reachable node): each scans n nodes for the minimum, then
// reads the current row word by word (RELAX_RD, RELAX) through the one ram
// port and one shared add/compare; a last scan finds no node left and the n
// results follow one a cycle when not stalled. Results wait in an output
// register, and no request is taken while one is waiting.
// ----------------------------------------------------------------------------
module dijkstra_shortest_paths_matrix_unit #(
	parameter int MAX_NODES   = dsp_pkg::MAX_NODES_DEF,
	parameter int WEIGHT_BITS = dsp_pkg::WEIGHT_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [1:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// mode[1:0], from_node[5:2], to_node[9:6], weight[25:10], source_node[29:26]
	input  wire logic [31:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// status[0], node[4:1], distance[24:5], predecessor[28:25], reachable[29]
	output logic [31:0]      m_tdata,
	output logic             m_tlast
);
	import dsp_pkg::*;

	localparam int NB = $clog2(MAX_NODES);
	localparam int AB = 2 * NB;
	localparam int CB = $clog2(MAX_NODES + 1);
	localparam logic [DIST_BITS:0] DMAX = {1'b0, {DIST_BITS{1'b1}}};

	state_t state_q, state_d;
	logic [4:0]  node_count_q;
	logic [CB-1:0] n_act;
	logic [1:0]  mode_q;
	logic [3:0]  a_q, b_q, src_q;
	logic [WEIGHT_BITS-1:0] w_q;
	logic [AB-1:0] clr_q;
	logic          boot_q;
	logic [NB-1:0] i_q, cur_q, best_q;
	logic          best_v_q;
	logic [MAX_NODES-1:0] visited_q, found_q, src_oh;
	logic [DIST_BITS-1:0] dist_q [MAX_NODES];
	logic [NB-1:0]        par_q  [MAX_NODES];
	logic          outv_q, olast_q, out_load;
	logic [29:0]   odata_q;
	logic          ram_we;
	logic [AB-1:0] ram_addr;
	logic [WEIGHT_BITS-1:0] ram_wd, ram_rd;
	logic [DIST_BITS:0] sum;
	logic [DIST_BITS-1:0] dsat;
	logic last_i, a_bad, b_bad, s_bad;

	dsp_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(1 << AB)) u_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wd), .rdata(ram_rd)
	);

	always_comb begin
		if (node_count_q == 5'd0) n_act = CB'(1);
		else if (32'(node_count_q) > MAX_NODES) n_act = CB'(MAX_NODES);
		else n_act = CB'(node_count_q);
	end

	assign a_bad  = 32'(a_q) >= 32'(n_act);
	assign b_bad  = 32'(b_q) >= 32'(n_act);
	assign s_bad  = 32'(src_q) >= 32'(n_act);
	assign last_i = 32'(i_q) + 1 == 32'(n_act);
	assign src_oh = MAX_NODES'(1) << NB'(src_q);
	assign pready = 1'b1;
	assign prdata = (paddr == REG_NODE_COUNT) ? {27'd0, node_count_q} : 32'd0;
	assign s_tready = (state_q == ST_IDLE) && !outv_q;
	assign m_tvalid = outv_q;
	assign m_tdata  = {2'b00, odata_q};
	assign m_tlast  = olast_q;
	assign out_load = (state_q == ST_ACK) || (state_q == ST_EMIT && (!outv_q || m_tready));

	// shared add and saturate
	assign sum  = {1'b0, dist_q[cur_q]} + (DIST_BITS + 1)'(ram_rd);
	assign dsat = (sum > DMAX) ? DIST_BITS'(DMAX) : sum[DIST_BITS-1:0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:
				if (s_tvalid && s_tready) begin
					unique case (s_tdata[1:0])
						MODE_CLEAR: state_d = ST_CLEAR;
						MODE_RUN:   state_d = ST_INIT;
						default:    state_d = ST_WRITE2;
					endcase
				end
			ST_CLEAR:    if (&clr_q) state_d = boot_q ? ST_IDLE : ST_ACK;
			ST_WRITE2:   state_d = ST_ACK;
			ST_INIT:     state_d = s_bad ? ST_ACK : ST_SCAN;
			ST_SCAN:     if (last_i) state_d = ST_RELAX_RD;
			ST_RELAX_RD: state_d = best_v_q ? ST_RELAX : ST_EMIT_RD;
			ST_RELAX:    state_d = last_i ? ST_SCAN : ST_RELAX_RD;
			ST_EMIT_RD:  state_d = ST_EMIT;
			ST_EMIT:     if (!outv_q || m_tready) state_d = last_i ? ST_IDLE : ST_EMIT;
			ST_ACK:      state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ram_we   = 1'b0;
		ram_addr = {best_q, i_q};
		ram_wd   = w_q;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we   = 1'b1;
				ram_addr = clr_q;
				ram_wd   = '0;
			end
			ST_WRITE2: begin
				ram_we   = !(a_bad || b_bad);
				ram_addr = {NB'(a_q), NB'(b_q)};
			end
			ST_ACK: begin
				ram_we   = (mode_q == MODE_UNDIRECTED) && !(a_bad || b_bad);
				ram_addr = {NB'(b_q), NB'(a_q)};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			node_count_q <= 5'd16;
			clr_q        <= '0;
			boot_q       <= 1'b1;
			outv_q       <= 1'b0;
			mode_q       <= MODE_CLEAR;
			i_q          <= '0;
			best_v_q     <= 1'b0;
			visited_q    <= '0;
			found_q      <= '0;
		end else begin
			state_q <= state_d;
			if (psel && penable && pwrite && paddr == REG_NODE_COUNT)
				node_count_q <= pwdata[4:0];
			outv_q <= out_load || (outv_q && !m_tready);
			unique case (state_q)
				ST_IDLE:
					if (s_tvalid && s_tready) begin
						mode_q <= s_tdata[1:0];
						a_q    <= s_tdata[5:2];
						b_q    <= s_tdata[9:6];
						w_q    <= WEIGHT_BITS'(s_tdata[25:10]);
						src_q  <= s_tdata[29:26];
						clr_q  <= '0;
					end
				ST_CLEAR: begin
					clr_q <= clr_q + AB'(1);
					if (&clr_q) boot_q <= 1'b0;
				end
				ST_INIT: begin
					visited_q <= '0;
					found_q   <= src_oh;
					dist_q[NB'(src_q)] <= '0;
					par_q[NB'(src_q)]  <= NB'(src_q);
					i_q      <= '0;
					best_v_q <= 1'b0;
				end
				ST_SCAN: begin
					if (found_q[i_q] && !visited_q[i_q] &&
					    (!best_v_q || dist_q[i_q] < dist_q[best_q])) begin
						best_q   <= i_q;
						best_v_q <= 1'b1;
					end
					i_q <= last_i ? '0 : i_q + NB'(1);
				end
				ST_RELAX_RD: begin
					if (best_v_q) begin
						if (i_q == '0) begin
							cur_q <= best_q;
							visited_q[best_q] <= 1'b1;
						end
					end else begin
						i_q <= '0;
					end
				end
				ST_RELAX: begin
					if (ram_rd != '0 && !visited_q[i_q] &&
					    (!found_q[i_q] || dsat < dist_q[i_q])) begin
						dist_q[i_q]  <= dsat;
						par_q[i_q]   <= cur_q;
						found_q[i_q] <= 1'b1;
					end
					if (last_i) begin
						i_q      <= '0;
						best_v_q <= 1'b0;
					end else i_q <= i_q + NB'(1);
				end
				ST_EMIT_RD: ;
				ST_EMIT:
					if (!outv_q || m_tready) begin
						olast_q <= last_i;
						odata_q <= {found_q[i_q],
						            found_q[i_q] ? NODE_FLD_BITS'(par_q[i_q]) : 4'd0,
						            found_q[i_q] ? dist_q[i_q] : 20'd0,
						            NODE_FLD_BITS'(i_q), 1'b0};
						i_q <= i_q + NB'(1);
					end
				ST_ACK: begin
					olast_q <= 1'b1;
					unique case (mode_q)
						MODE_CLEAR: odata_q <= '0;
						MODE_RUN:   odata_q <= {25'd0, src_q, 1'b1};
						default:    odata_q <= {25'd0, a_q, a_bad || b_bad};
					endcase
				end
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== tb/sv/tb_dijkstra_shortest_paths_matrix_unit.sv =====
// ----------------------------------------------------------------------------
// tb_dijkstra_shortest_paths_matrix_unit
// checks edge writes, clears and shortest path runs against a local predictor
// ----------------------------------------------------------------------------
// Requests come from a queue filled by the stimulus process and are driven with
// random gaps. Each accepted request is predicted at once; the monitor compares
// every result with the oldest prediction. The node count is changed between
// phases while the unit is idle.
// ----------------------------------------------------------------------------
module tb_dijkstra_shortest_paths_matrix_unit;
	import dsp_pkg::*;

	typedef struct packed {
		logic        status;
		logic [3:0]  node;
		logic [19:0] distance;
		logic [3:0]  predecessor;
		logic        reachable;
		logic        last;
	} path_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [1:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	// mode, from_node, to_node, weight, source_node
	logic [31:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// status, node, distance, predecessor, reachable
	logic [31:0] m_tdata;
	logic        m_tlast;

	logic [31:0]  request_queue[$];
	path_result_t expected_results[$];
	logic [15:0]  edge_weight[16][16];
	int           nodes_in_use = 16;
	int           failures = 0;
	int           cycle_count = 0;
	int           send_gap = 0;
	int           ready_gap = 0;
	int           phase_counts[7] = '{31, 1, 2, 6, 16, 9, 17};

	dijkstra_shortest_paths_matrix_unit i_dut (.*);

	always #2 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [31:0] pack_request(logic [1:0] mode, logic [3:0] a, logic [3:0] b,
			logic [15:0] w, logic [3:0] src);
		return {2'b0, src, w, b, a, mode};
	endfunction

	task automatic predict_request(input logic [31:0] req);
		logic [1:0]  mode;
		logic [3:0]  a, b, src;
		logic [15:0] w;
		logic [19:0] best_dist[16];
		logic [3:0]  parent[16];
		bit          seen[16], done[16];
		int          cur;
		logic [20:0] sum;
		path_result_t r;
		mode = req[1:0];
		a = req[5:2];
		b = req[9:6];
		w = req[25:10];
		src = req[29:26];
		r = '0;
		r.last = 1'b1;
		if (mode == MODE_CLEAR) begin
			foreach (edge_weight[i, j]) edge_weight[i][j] = '0;
			expected_results.push_back(r);
		end else if (mode != MODE_RUN) begin
			r.node = a;
			if (a >= nodes_in_use || b >= nodes_in_use) begin
				r.status = 1'b1;
			end else begin
				edge_weight[a][b] = w;
				if (mode == MODE_UNDIRECTED) edge_weight[b][a] = w;
			end
			expected_results.push_back(r);
		end else if (src >= nodes_in_use) begin
			r.status = 1'b1;
			r.node = src;
			expected_results.push_back(r);
		end else begin
			for (int i = 0; i < 16; i++) begin
				best_dist[i] = '0;
				parent[i] = '0;
				seen[i] = 0;
				done[i] = 0;
			end
			parent[src] = src;
			seen[src] = 1;
			forever begin
				cur = nodes_in_use;
				for (int i = 0; i < nodes_in_use; i++)
					if (seen[i] && !done[i] &&
					    (cur == nodes_in_use || best_dist[i] < best_dist[cur]))
						cur = i;
				if (cur == nodes_in_use) break;
				done[cur] = 1;
				for (int i = 0; i < nodes_in_use; i++) begin
					if (edge_weight[cur][i] == 0 || done[i]) continue;
					sum = best_dist[cur] + edge_weight[cur][i];
					if (sum[20]) sum = 21'hFFFFF;
					if (!seen[i] || sum[19:0] < best_dist[i]) begin
						best_dist[i] = sum[19:0];
						parent[i] = cur[3:0];
						seen[i] = 1;
					end
				end
			end
			for (int i = 0; i < nodes_in_use; i++) begin
				r = '0;
				r.node = i[3:0];
				if (seen[i]) begin
					r.distance = best_dist[i];
					r.predecessor = parent[i];
					r.reachable = 1'b1;
				end
				r.last = (i == nodes_in_use - 1);
				expected_results.push_back(r);
			end
		end
	endtask

	// driver
	always @(posedge clk) begin
		if (s_tvalid && s_tready) predict_request(s_tdata);
		if (!s_tvalid || s_tready) begin
			if (send_gap > 0 || request_queue.size() == 0) begin
				s_tvalid <= 1'b0;
				if (send_gap > 0) send_gap <= send_gap - 1;
			end else begin
				s_tvalid <= 1'b1;
				s_tdata <= request_queue.pop_front();
				send_gap <= pick_gap();
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		path_result_t got, want;
		cycle_count <= cycle_count + 1;
		if (m_tvalid && m_tready) begin
			got.status = m_tdata[0];
			got.node = m_tdata[4:1];
			got.distance = m_tdata[24:5];
			got.predecessor = m_tdata[28:25];
			got.reachable = m_tdata[29];
			got.last = m_tlast;
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				failures++;
			end else begin
				want = expected_results.pop_front();
				if (got.status != want.status)
					$display("%0t: status exp %h got %h", $time, want.status, got.status);
				if (got.node != want.node)
					$display("%0t: node exp %h got %h", $time, want.node, got.node);
				if (got.distance != want.distance)
					$display("%0t: distance exp %h got %h", $time, want.distance,
						got.distance);
				if (got.predecessor != want.predecessor)
					$display("%0t: predecessor exp %h got %h", $time, want.predecessor,
						got.predecessor);
				if (got.reachable != want.reachable)
					$display("%0t: reachable exp %h got %h", $time, want.reachable,
						got.reachable);
				if (got.last != want.last)
					$display("%0t: last exp %h got %h", $time, want.last, got.last);
				if (got != want) failures++;
			end
		end
		if (ready_gap > 0) begin
			m_tready <= 1'b0;
			ready_gap <= ready_gap - 1;
		end else begin
			m_tready <= 1'b1;
			ready_gap <= pick_gap();
		end
	end

	always @(posedge clk) begin
		if (cycle_count > 3000000) begin
			$display("tb_dijkstra_shortest_paths_matrix_unit NOT OK");
			$finish;
		end
	end

	task automatic write_node_count(input int count);
		@(posedge clk);
		psel <= 1'b1;
		paddr <= REG_NODE_COUNT;
		pwrite <= 1'b1;
		pwdata <= count;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		nodes_in_use = (count < 1) ? 1 : (count > 16 ? 16 : count);
	endtask

	task automatic wait_idle();
		wait (request_queue.size() == 0 && !s_tvalid && expected_results.size() == 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic add_random_requests(input int count);
		int r;
		logic [15:0] w;
		for (int k = 0; k < count; k++) begin
			r = $urandom_range(0, 99);
			w = ($urandom_range(0, 9) == 0) ? (($urandom_range(0, 1)) ? 16'hFFFF : 16'd0)
				: 16'($urandom_range(1, 300)) | ($urandom_range(0, 7) == 0 ? 16'($urandom) : 16'd0);
			if (r < 2)
				request_queue.push_back(pack_request(MODE_CLEAR, 4'($urandom), 4'($urandom),
					16'($urandom), 4'($urandom)));
			else if (r < 80)
				request_queue.push_back(pack_request(r < 40 ? MODE_DIRECTED : MODE_UNDIRECTED,
					4'($urandom_range(0, nodes_in_use)), 4'($urandom_range(0, nodes_in_use)),
					w, 4'($urandom)));
			else
				request_queue.push_back(pack_request(MODE_RUN, 4'($urandom), 4'($urandom),
					16'($urandom), 4'($urandom_range(0, nodes_in_use))));
		end
	endtask

	initial begin
		foreach (edge_weight[i, j]) edge_weight[i][j] = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		// directed part
		request_queue.push_back(pack_request(MODE_RUN, 4'd0, 4'd0, 16'd0, 4'd0));
		request_queue.push_back(pack_request(MODE_DIRECTED, 4'd0, 4'd15, 16'hFFFF, 4'd0));
		request_queue.push_back(pack_request(MODE_UNDIRECTED, 4'd15, 4'd3, 16'hFFFF, 4'd0));
		request_queue.push_back(pack_request(MODE_DIRECTED, 4'd0, 4'd3, 16'd1, 4'd0));
		request_queue.push_back(pack_request(MODE_DIRECTED, 4'd0, 4'd1, 16'd5, 4'd0));
		request_queue.push_back(pack_request(MODE_DIRECTED, 4'd0, 4'd2, 16'd5, 4'd0));
		request_queue.push_back(pack_request(MODE_DIRECTED, 4'd1, 4'd4, 16'd1, 4'd0));
		request_queue.push_back(pack_request(MODE_DIRECTED, 4'd2, 4'd4, 16'd1, 4'd0));
		request_queue.push_back(pack_request(MODE_RUN, 4'd0, 4'd0, 16'd0, 4'd0));
		request_queue.push_back(pack_request(MODE_RUN, 4'd0, 4'd0, 16'd0, 4'd15));
		request_queue.push_back(pack_request(MODE_DIRECTED, 4'd0, 4'd1, 16'd0, 4'd0));
		request_queue.push_back(pack_request(MODE_RUN, 4'd0, 4'd0, 16'd0, 4'd0));
		request_queue.push_back(pack_request(MODE_CLEAR, 4'd15, 4'd15, 16'hFFFF, 4'd15));
		request_queue.push_back(pack_request(MODE_RUN, 4'd0, 4'd0, 16'd0, 4'd7));
		wait_idle();
		write_node_count(5);
		request_queue.push_back(pack_request(MODE_DIRECTED, 4'd5, 4'd0, 16'd3, 4'd0));
		request_queue.push_back(pack_request(MODE_UNDIRECTED, 4'd0, 4'd5, 16'd3, 4'd0));
		request_queue.push_back(pack_request(MODE_RUN, 4'd0, 4'd0, 16'd0, 4'd5));
		request_queue.push_back(pack_request(MODE_RUN, 4'd0, 4'd0, 16'd0, 4'd4));
		wait_idle();
		write_node_count(0);
		request_queue.push_back(pack_request(MODE_RUN, 4'd0, 4'd0, 16'd0, 4'd0));
		request_queue.push_back(pack_request(MODE_DIRECTED, 4'd0, 4'd1, 16'd2, 4'd0));
		wait_idle();
		// random phases over several node counts
		foreach (phase_counts[p]) begin
			write_node_count(phase_counts[p]);
			add_random_requests(phase_counts[p] < 3 ? 20 : 55);
			wait_idle();
		end
		repeat (50) @(posedge clk);
		if (failures == 0)
			$display("tb_dijkstra_shortest_paths_matrix_unit OK");
		else
			$display("tb_dijkstra_shortest_paths_matrix_unit NOT OK");
		$finish;
	end
endmodule
